// ----- rtl/pps_frame_timestamp_aligner_macros.svh -----
// assertion macros for the pps frame timestamp aligner
// used by pps_frame_timestamp_aligner.sv; expects clk and rst_n in scope
`ifndef PPS_FRAME_TIMESTAMP_ALIGNER_MACROS_SVH
`define PPS_FRAME_TIMESTAMP_ALIGNER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PFTA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfta assertion failed");
// next-cycle implication
`define PFTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfta assertion failed");
`else
`define PFTA_ASSERT_IMPLY(label, ante, cons)
`define PFTA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/pfta_pkg.sv -----
// types and constants for the pps frame timestamp aligner
// no dependencies; used by pps_frame_timestamp_aligner.sv
package pfta_pkg;

    // frame period and half period in ns
    localparam logic [26:0] FRAME_NS      = 27'd100_000_000;
    localparam logic [25:0] HALF_FRAME_NS = 26'd50_000_000;
    // frame index above this flags a lost pps
    localparam logic [7:0]  PPS_LOST_LIMIT = 8'd12;
    // reset value of the alignment threshold
    localparam logic [29:0] THRESH_RESET = 30'd45_000_000;
    // rounded offsets at or above this value saturate the quotient
    localparam logic [35:0] ROUND_SAT_NS = 36'd51_100_000_000;
    localparam logic [8:0]  Q_CLAMP      = 9'd511;
    // ceil(2^47 / 390625): (x >> 8) * RECIP >> 47 == x / 1e8 for x < 2^36
    localparam logic [28:0] RECIP       = 29'd360_287_971;
    localparam int          RECIP_SHIFT = 47;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SERIAL_DELAY   = 3'd0,
        REG_EXPOSURE_DELAY = 3'd1,
        REG_TRANSFER_DELAY = 3'd2,
        REG_ALIGN_THRESH   = 3'd3
    } cfg_reg_t;

    // item modes
    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_PPS   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [62:0] local_time_ns;
        logic [62:0] gps_time_ns;
    } item_t;

    typedef struct packed {
        logic [62:0] timestamp_ns;
        logic [7:0]  frames_since_pps;
        logic        was_first_after_pps;
        logic [7:0]  lost_at_pps;
        logic [7:0]  gap_frames;
        logic [15:0] lost_total;
        logic        pps_lost;
    } result_t;

endpackage

// ----- rtl/pps_frame_timestamp_aligner.sv -----
// pps frame timestamp aligner, top level
// depends on pfta_pkg and pps_frame_timestamp_aligner_macros.svh
//
// Usage:
//   item channel (item_valid / item_stall / item) carries PPS events
//   (mode 1: local receive time and GPS time) and frame arrivals (mode 0:
//   local capture time). Each frame after the first PPS yields one
//   transaction on the result channel (result_valid / result_stall /
//   result); PPS events and frames before the first PPS yield none.
//   Config writes (cfg_wr_en, cfg_index, cfg_data) set the serial,
//   exposure and transfer delays and the alignment threshold; write them
//   only while the block is idle. Indexes beyond the list are ignored.
// Timing:
//   one item accepted per cycle, and back-to-back items stream at full
//   rate, while the result is not stalled. A frame's result is built in
//   stages: the accepting edge registers the offsets to the PPS and the
//   rounded frame count, the second stage the frame index and timestamp.
// Reset: control state clears, the threshold returns to 45 ms, no results.
// Stall: a stalled result holds; items are still taken until the first stage
//   is full, after which item_stall rises until the result is taken.
`include "pps_frame_timestamp_aligner_macros.svh"

module pps_frame_timestamp_aligner
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [29:0]      cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  pfta_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output pfta_pkg::result_t result
);

    // first stage register contents
    typedef struct packed {
        logic        is_pps;
        logic        last_le_this;
        logic        last_lt_thr;
        logic        this_lt_thr;
        logic        q_neg;
        logic [8:0]  q;
        logic [62:0] gps;
    } stage_a_t;

    // configuration
    logic [29:0] serial_delay_reg, serial_delay_next;
    logic [29:0] exposure_delay_reg, exposure_delay_next;
    logic [29:0] transfer_delay_reg, transfer_delay_next;
    logic [29:0] align_thresh_reg, align_thresh_next;

    // first stage state
    logic signed [63:0] pps_local_reg, pps_local_next;
    logic [62:0]        pps_gps_reg, pps_gps_next;
    logic signed [63:0] prev_frame_reg, prev_frame_next;
    logic               first_pps_seen_reg, first_pps_seen_next;
    logic               a_valid_reg, a_valid_next;
    stage_a_t           a_reg, a_next;

    // second stage state
    logic               update_pending_reg, update_pending_next;
    logic [7:0]         frame_index_reg, frame_index_next;
    logic [15:0]        lost_count_reg, lost_count_next;
    logic               result_valid_reg, result_valid_next;
    pfta_pkg::result_t  result_reg, result_next;

    logic in_accept, a_move, b_fire;

    // config register writes
    always_comb
    begin
        serial_delay_next   = serial_delay_reg;
        exposure_delay_next = exposure_delay_reg;
        transfer_delay_next = transfer_delay_reg;
        align_thresh_next   = align_thresh_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                pfta_pkg::REG_SERIAL_DELAY:   serial_delay_next   = cfg_data;
                pfta_pkg::REG_EXPOSURE_DELAY: exposure_delay_next = cfg_data;
                pfta_pkg::REG_TRANSFER_DELAY: transfer_delay_next = cfg_data;
                pfta_pkg::REG_ALIGN_THRESH:   align_thresh_next   = cfg_data;
                default: ;
            endcase
        end
    end

    // handshake control
    assign a_move     = !result_valid_reg || !result_stall;
    assign item_stall = a_valid_reg && !a_move;
    assign in_accept  = item_valid && !item_stall;
    assign b_fire     = a_valid_reg && a_move;

    // first stage: corrected times, offsets to pps, rounded frame count
    logic signed [64:0] local_s, now_s, pps_new_s, diff_this, diff_last;
    logic [64:0]        mag_this65, mag_last65, x;
    logic [63:0]        mag_this, mag_last;
    logic               neg_this, neg_last, near_zero, sat;
    logic [27:0]        y;
    logic [56:0]        prod;
    logic [8:0]         q_raw, q_val;
    logic               gps_changed, is_pps;

    always_comb
    begin
        local_s   = $signed({2'b00, item.local_time_ns});
        now_s     = local_s - $signed({35'd0, transfer_delay_reg})
                    - $signed({35'd0, exposure_delay_reg});
        pps_new_s = local_s - $signed({35'd0, serial_delay_reg});
        diff_this = now_s - $signed({pps_local_reg[63], pps_local_reg});
        diff_last = $signed({prev_frame_reg[63], prev_frame_reg})
                    - $signed({pps_local_reg[63], pps_local_reg});
        neg_this  = diff_this[64];
        neg_last  = diff_last[64];
        mag_this65 = neg_this ? (65'd0 - 65'(diff_this)) : 65'(diff_this);
        mag_last65 = neg_last ? (65'd0 - 65'(diff_last)) : 65'(diff_last);
        mag_this  = mag_this65[63:0];
        mag_last  = mag_last65[63:0];

        // rounding offset, truncated toward zero
        near_zero = neg_this && (mag_this <= {38'd0, pfta_pkg::HALF_FRAME_NS});
        if (!neg_this)
            x = {1'b0, mag_this} + {39'd0, pfta_pkg::HALF_FRAME_NS};
        else if (near_zero)
            x = 65'd0;
        else
            x = {1'b0, mag_this - {38'd0, pfta_pkg::HALF_FRAME_NS}};
        sat   = x >= {29'd0, pfta_pkg::ROUND_SAT_NS};
        y     = x[35:8];
        prod  = 57'(y) * 57'(pfta_pkg::RECIP);
        q_raw = prod[pfta_pkg::RECIP_SHIFT +: 9];
        q_val = sat ? pfta_pkg::Q_CLAMP : q_raw;

        is_pps      = item.mode == pfta_pkg::MODE_PPS;
        gps_changed = item.gps_time_ns != pps_gps_reg;

        a_next.is_pps       = is_pps;
        a_next.last_le_this = mag_last <= mag_this;
        a_next.last_lt_thr  = mag_last < {34'd0, align_thresh_reg};
        a_next.this_lt_thr  = mag_this < {34'd0, align_thresh_reg};
        a_next.q_neg        = neg_this && !near_zero && (q_val != 9'd0);
        a_next.q            = q_val;
        a_next.gps          = pps_gps_reg;

        pps_local_next      = pps_local_reg;
        pps_gps_next        = pps_gps_reg;
        prev_frame_next     = prev_frame_reg;
        first_pps_seen_next = first_pps_seen_reg;
        a_valid_next        = a_move ? 1'b0 : a_valid_reg;
        if (in_accept)
        begin
            if (is_pps)
            begin
                a_valid_next = gps_changed;
                if (gps_changed)
                begin
                    pps_local_next      = pps_new_s[63:0];
                    pps_gps_next        = item.gps_time_ns;
                    first_pps_seen_next = 1'b1;
                end
            end
            else
            begin
                a_valid_next = first_pps_seen_reg;
                if (first_pps_seen_reg)
                    prev_frame_next = now_s[63:0];
            end
        end
    end

    // second stage: frame index, lost and gap counts, timestamp
    logic [7:0]  q_sat8, incre, fi_first, fi_step, fi_new, lost8, gap8;
    logic [9:0]  gap10;
    logic [16:0] lost_sum;
    logic [15:0] lost_new;
    logic        aligned, gap_cond;
    logic [34:0] fi_mul;
    logic [63:0] ts64;

    always_comb
    begin
        q_sat8   = (a_reg.q > 9'd255) ? 8'd255 : a_reg.q[7:0];
        aligned  = a_reg.last_le_this ? a_reg.last_lt_thr : a_reg.this_lt_thr;
        incre    = aligned ? {7'd0, a_reg.last_le_this}
                           : (a_reg.q_neg ? 8'd0 : q_sat8);
        fi_first = (incre == 8'd255) ? 8'd255 : incre + 8'd1;
        lost8    = aligned ? 8'd0 : incre;
        lost_sum = {1'b0, lost_count_reg} + {9'd0, lost8};
        lost_new = lost_sum[16] ? 16'hFFFF : lost_sum[15:0];
        gap_cond = !a_reg.q_neg && (a_reg.q > {1'b0, frame_index_reg});
        gap10    = {1'b0, a_reg.q} + 10'd1 - {2'b00, frame_index_reg};
        gap8     = (gap10 > 10'd255) ? 8'd255 : gap10[7:0];
        fi_step  = (frame_index_reg == 8'd255) ? 8'd255 : frame_index_reg + 8'd1;

        if (update_pending_reg)
            fi_new = fi_first;
        else if (gap_cond)
            fi_new = frame_index_reg;
        else
            fi_new = fi_step;

        fi_mul = 35'(fi_new) * 35'(pfta_pkg::FRAME_NS);
        ts64   = {29'd0, fi_mul} + {1'b0, a_reg.gps}
                 + {35'd0, exposure_delay_reg[29:1]};

        result_next.timestamp_ns        = ts64[62:0];
        result_next.frames_since_pps    = fi_new;
        result_next.was_first_after_pps = update_pending_reg;
        result_next.lost_at_pps         = update_pending_reg ? lost8 : 8'd0;
        result_next.gap_frames          = (!update_pending_reg && gap_cond) ? gap8 : 8'd0;
        result_next.lost_total          = update_pending_reg ? lost_new : lost_count_reg;
        result_next.pps_lost            = fi_new > pfta_pkg::PPS_LOST_LIMIT;

        update_pending_next = update_pending_reg;
        frame_index_next    = frame_index_reg;
        lost_count_next     = lost_count_reg;
        if (b_fire)
        begin
            if (a_reg.is_pps)
                update_pending_next = 1'b1;
            else
            begin
                update_pending_next = 1'b0;
                frame_index_next    = fi_new;
                lost_count_next     = result_next.lost_total;
            end
        end
        result_valid_next = a_move ? (a_valid_reg && !a_reg.is_pps) : result_valid_reg;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_delay_reg   <= 30'd0;
            exposure_delay_reg <= 30'd0;
            transfer_delay_reg <= 30'd0;
            align_thresh_reg   <= pfta_pkg::THRESH_RESET;
            pps_local_reg      <= 64'sd0;
            pps_gps_reg        <= 63'd0;
            prev_frame_reg     <= 64'sd0;
            first_pps_seen_reg <= 1'b0;
            a_valid_reg        <= 1'b0;
            update_pending_reg <= 1'b0;
            frame_index_reg    <= 8'd0;
            lost_count_reg     <= 16'd0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            serial_delay_reg   <= serial_delay_next;
            exposure_delay_reg <= exposure_delay_next;
            transfer_delay_reg <= transfer_delay_next;
            align_thresh_reg   <= align_thresh_next;
            pps_local_reg      <= pps_local_next;
            pps_gps_reg        <= pps_gps_next;
            prev_frame_reg     <= prev_frame_next;
            first_pps_seen_reg <= first_pps_seen_next;
            a_valid_reg        <= a_valid_next;
            update_pending_reg <= update_pending_next;
            frame_index_reg    <= frame_index_next;
            lost_count_reg     <= lost_count_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            a_reg <= a_next;
        if (b_fire && !a_reg.is_pps)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `PFTA_ASSERT_IMPLY(a_stall_only_full, item_stall,
                       a_valid_reg && result_valid_reg && result_stall)
    `PFTA_ASSERT_IMPLY(a_lost_only_first, result_valid_reg && (result_reg.lost_at_pps != 8'd0),
                       result_reg.was_first_after_pps)
    `PFTA_ASSERT_IMPLY(a_gap_not_first, result_valid_reg && (result_reg.gap_frames != 8'd0),
                       !result_reg.was_first_after_pps && (result_reg.gap_frames != 8'd1))
    `PFTA_ASSERT_NEXT(a_pending_consumed, b_fire && !a_reg.is_pps && update_pending_reg,
                      !update_pending_reg)
    `PFTA_ASSERT_NEXT(a_lost_monotonic, 1'b1, lost_count_reg >= $past(lost_count_reg))

endmodule

// ----- bench/tb_pps_frame_timestamp_aligner.sv -----
// self-checking testbench for pps_frame_timestamp_aligner
// needs pfta_pkg and the aligner rtl; drives pps and frame transactions
// and checks every frame stamp against a cycle-free model of the aligner
`timescale 1ns / 1ps

module tb_pps_frame_timestamp_aligner;

    localparam int     RESET_CYCLES = 4;
    localparam int     SETTLE       = 8;
    localparam int     TAIL         = 12;
    localparam int     HOLD_LEN     = 300;
    localparam int     QUIET_LIMIT  = 3000;
    localparam int     IDX_TOP      = 7;
    localparam int     SAT8         = 255;
    localparam int     SAT16        = 65535;
    localparam int     MISMATCH_CAP = 30;
    localparam longint SEC_NS       = 1_000_000_000;
    localparam longint FRAME_LEN    = longint'(pfta_pkg::FRAME_NS);
    localparam longint MS           = 1_000_000;
    localparam int     CFG_MAX      = 999_999_999;
    localparam logic [62:0] MAX63   = '1;

    // expected frame stamps, kept in step with every accepted transaction
    class stamp_scoreboard;
        bit [29:0]          serial_dly, expo_dly, xfer_dly, align_thr;
        bit signed [65:0]   pps_local, prev_frame;
        bit [62:0]          pps_gps;
        bit                 upd_pending, pps_seen;
        bit [7:0]           frame_idx;
        bit [15:0]          lost_tally;
        pfta_pkg::result_t  stamps_due[$];
        int                 errs;

        function new();
            align_thr = pfta_pkg::THRESH_RESET;
        endfunction

        function void write_reg(bit [2:0] idx, bit [29:0] val);
            case (idx)
                pfta_pkg::REG_SERIAL_DELAY:   serial_dly = val;
                pfta_pkg::REG_EXPOSURE_DELAY: expo_dly   = val;
                pfta_pkg::REG_TRANSFER_DELAY: xfer_dly   = val;
                pfta_pkg::REG_ALIGN_THRESH:   align_thr  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return stamps_due.size();
        endfunction

        // advance the aligner by one input transaction
        function void accept_item(pfta_pkg::item_t it);
            bit signed [65:0]  now, d_this, d_last;
            bit [65:0]         this_a, last_a, q, incre, lost, gap;
            bit                this_neg, q_neg, first, aligned;
            bit [63:0]         ts;
            pfta_pkg::result_t want;
            if (it.mode == pfta_pkg::MODE_PPS)
            begin
                // a pulse only counts when its gps second is new
                if (it.gps_time_ns != pps_gps)
                begin
                    pps_local   = $signed({3'b000, it.local_time_ns})
                                - $signed({36'd0, serial_dly});
                    pps_gps     = it.gps_time_ns;
                    upd_pending = 1'b1;
                    pps_seen    = 1'b1;
                end
                return;
            end
            if (!pps_seen)
                return;

            // corrected capture time and distances to the pulse
            now = $signed({3'b000, it.local_time_ns}) - $signed({36'd0, xfer_dly})
                - $signed({36'd0, expo_dly});
            d_this   = now - pps_local;
            d_last   = prev_frame - pps_local;
            this_neg = (d_this < 0);
            this_a   = this_neg ? -d_this : d_this;
            last_a   = (d_last < 0) ? -d_last : d_last;

            // offset rounded to whole frames, truncated toward zero
            q_neg = 1'b0;
            if (!this_neg)
                q = (this_a + pfta_pkg::HALF_FRAME_NS) / pfta_pkg::FRAME_NS;
            else if (this_a <= pfta_pkg::HALF_FRAME_NS)
                q = '0;
            else
            begin
                q     = (this_a - pfta_pkg::HALF_FRAME_NS) / pfta_pkg::FRAME_NS;
                q_neg = (q != 0);
            end

            first = 1'b0;
            lost  = '0;
            gap   = '0;
            if (upd_pending)
            begin
                // first frame after a pulse sets the in-second index
                aligned = 1'b0;
                incre   = '0;
                if (last_a <= this_a)
                begin
                    if (last_a < align_thr)
                    begin
                        incre   = 66'd1;
                        aligned = 1'b1;
                    end
                end
                else if (this_a < align_thr)
                    aligned = 1'b1;
                if (!aligned)
                begin
                    incre      = q_neg ? 66'd0 : ((q > SAT8) ? 66'(SAT8) : q);
                    lost       = incre;
                    lost_tally = (lost_tally + incre > SAT16) ? 16'(SAT16)
                                                              : 16'(lost_tally + incre);
                end
                frame_idx   = (incre + 1 > SAT8) ? 8'(SAT8) : 8'(incre + 1);
                upd_pending = 1'b0;
                first       = 1'b1;
            end
            else if (!q_neg && q > frame_idx)
            begin
                gap = q + 1 - frame_idx;
                if (gap > SAT8)
                    gap = 66'(SAT8);
            end
            else if (frame_idx != 8'(SAT8))
                frame_idx++;

            ts = frame_idx * pfta_pkg::FRAME_NS + pps_gps + (expo_dly >> 1);
            want.timestamp_ns        = ts[62:0];
            want.frames_since_pps    = frame_idx;
            want.was_first_after_pps = first;
            want.lost_at_pps         = lost[7:0];
            want.gap_frames          = gap[7:0];
            want.lost_total          = lost_tally;
            want.pps_lost            = (frame_idx > pfta_pkg::PPS_LOST_LIMIT);
            stamps_due.push_back(want);
            prev_frame = now;
        endfunction

        function void cmp(string name, bit [62:0] want, logic [62:0] got);
            if (got !== want)
            begin
                errs++;
                if (errs <= MISMATCH_CAP)
                    $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // compare one result transaction with the oldest expected stamp
        function void check_stamp(pfta_pkg::result_t got);
            pfta_pkg::result_t want;
            if (stamps_due.size() == 0)
            begin
                errs++;
                if (errs <= MISMATCH_CAP)
                    $error("timestamp_ns: expected none, got %0d", got.timestamp_ns);
                return;
            end
            want = stamps_due.pop_front();
            cmp("timestamp_ns", want.timestamp_ns, got.timestamp_ns);
            cmp("frames_since_pps", want.frames_since_pps, got.frames_since_pps);
            cmp("was_first_after_pps", want.was_first_after_pps, got.was_first_after_pps);
            cmp("lost_at_pps", want.lost_at_pps, got.lost_at_pps);
            cmp("gap_frames", want.gap_frames, got.gap_frames);
            cmp("lost_total", want.lost_total, got.lost_total);
            cmp("pps_lost", want.pps_lost, got.pps_lost);
        endfunction
    endclass

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [2:0]        cfg_index    = '0;
    logic [29:0]       cfg_data     = '0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    pfta_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    pfta_pkg::result_t result;

    stamp_scoreboard board;
    int          quiet       = 0;
    int          hold_cycles = 0;
    int          burst_left  = 0;
    int          gap_max     = 0;
    longint      sec_local;
    bit [62:0]   sec_gps;

    pps_frame_timestamp_aligner dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: stall pattern of its own, plus an occasional long hold-off
    initial
    begin : stall_gen
        int left;
        int pct;
        left = 0;
        pct  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                if (left == 0)
                begin
                    left = $urandom_range(10, 150);
                    case ($urandom_range(0, 4))
                        0, 1:    pct = 0;
                        2:       pct = 25;
                        3:       pct = 55;
                        default: pct = 90;
                    endcase
                end
                left--;
                result_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // result transaction check
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_stamp(result);
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || cfg_wr_en)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("[pps_frame_timestamp_aligner] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic bit [62:0] rand63();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic pfta_pkg::item_t frame_item(input longint t);
        pfta_pkg::item_t it;
        it.mode          = pfta_pkg::MODE_FRAME;
        it.local_time_ns = 63'(t);
        it.gps_time_ns   = rand63();
        return it;
    endfunction

    function automatic pfta_pkg::item_t pps_item(input longint t, input bit [62:0] g);
        pfta_pkg::item_t it;
        it.mode          = pfta_pkg::MODE_PPS;
        it.local_time_ns = 63'(t);
        it.gps_time_ns   = g;
        return it;
    endfunction

    // offer one transaction, in bursts with random gaps between them
    task automatic put(input pfta_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.accept_item(it);
    endtask

    // stop offering and wait until every stamp has come back
    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input bit [29:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input bit [29:0] ser, expo, xfer, thr);
        drain();
        write_cfg(pfta_pkg::REG_SERIAL_DELAY, ser);
        write_cfg(pfta_pkg::REG_EXPOSURE_DELAY, expo);
        write_cfg(pfta_pkg::REG_TRANSFER_DELAY, xfer);
        write_cfg(pfta_pkg::REG_ALIGN_THRESH, thr);
        // index past the register list, must change nothing
        write_cfg(3'($urandom_range(int'(pfta_pkg::REG_ALIGN_THRESH) + 1, IDX_TOP)),
                  30'($urandom));
    endtask

    // corner cases at reset settings: 0 delays, 45 ms threshold
    task automatic directed();
        longint b;
        bit [62:0] g;
        b = 1000 * SEC_NS;
        g = 63'd1_700_000_000_000_000_000;
        put(frame_item(b));                              // no pulse seen yet
        put(pps_item(b, '0));                            // gps 0 after reset, ignored
        put(frame_item(b + FRAME_LEN));
        put(pps_item(b + SEC_NS, g));
        put(frame_item(b + SEC_NS + 10 * MS));           // this frame aligned
        put(frame_item(b + SEC_NS + 110 * MS));          // count up
        put(frame_item(b + SEC_NS + 610 * MS));          // gap
        put(pps_item(b + SEC_NS + 700 * MS, g));         // repeated gps second
        put(pps_item(b + 2 * SEC_NS, g + SEC_NS));
        put(frame_item(b + 2 * SEC_NS + 70 * MS));       // unaligned, one lost
        put(pps_item(b + 3 * SEC_NS, g + 2 * SEC_NS));
        put(frame_item(b + 3 * SEC_NS - 300 * MS));      // negative offset
        put(pps_item(b + 4 * SEC_NS, g + 3 * SEC_NS));
        put(frame_item(b + 4 * SEC_NS + 1350 * MS));     // index past twelve
        put(pps_item(b + 5 * SEC_NS, g + 4 * SEC_NS));
        put(frame_item(b + 105 * SEC_NS));               // lost clamps, index saturates
        put(frame_item(b + 5 * SEC_NS + MS));            // saturated index holds
        put(frame_item(b + 200 * SEC_NS));               // gap clamps
        put(pps_item(b + 6 * SEC_NS, g + 5 * SEC_NS));
        put(frame_item(b + 6 * SEC_NS - 50 * MS));       // exactly half a frame early
        put(frame_item(b + 6 * SEC_NS - 150 * MS));      // negative count between pulses
        put(frame_item(b + 7 * SEC_NS - 40 * MS));
        put(pps_item(b + 7 * SEC_NS, g + 6 * SEC_NS));
        put(frame_item(b + 7 * SEC_NS + 40 * MS));       // tie goes to previous frame
        put(pps_item(b + 8 * SEC_NS, g + 7 * SEC_NS));
        put(frame_item(b + 8 * SEC_NS + 45 * MS));       // exactly on threshold
        put(pps_item(0, MAX63));
        put(frame_item(longint'(MAX63)));                // timestamp wraps
        put(frame_item(0));
    endtask

    // realistic seconds: pulse plus ten frames, with drops, late and
    // repeated pulses and missing pulses mixed in
    task automatic run_seconds(input int n);
        longint dly, ph, t, jit;
        bit     skip, twice;
        int     late_k;
        dly = longint'(board.xfer_dly) + longint'(board.expo_dly);
        ph  = longint'($urandom_range(0, 99_999_999));
        for (int s = 0; s < n; s++)
        begin
            sec_local += SEC_NS;
            sec_gps   += SEC_NS;
            skip   = ($urandom_range(0, 19) == 0);
            twice  = ($urandom_range(0, 14) == 0);
            late_k = ($urandom_range(0, 4) == 0) ? 1 : 0;
            // occasional phase jump, otherwise slow drift
            if ($urandom_range(0, 9) == 0)
                ph = longint'($urandom_range(0, 99_999_999));
            else
                ph = ph + longint'($urandom_range(0, 600_000)) - 300_000;
            if (ph < 0)
                ph = 0;
            if (ph >= FRAME_LEN)
                ph = FRAME_LEN - 1;
            for (int k = 0; k < 10; k++)
            begin
                if (k == late_k && !skip)
                begin
                    t = sec_local + longint'(board.serial_dly)
                      + longint'($urandom_range(0, 200_000));
                    put(pps_item(t, sec_gps));
                    if (twice)
                        put(pps_item(t + MS, sec_gps));
                end
                jit = longint'($urandom_range(0, 1_000_000)) - 500_000;
                if ($urandom_range(0, 19) != 0)
                    put(frame_item(sec_local + ph + k * FRAME_LEN + jit + dly));
            end
        end
    endtask

    // unrelated random transactions, including near-zero local times
    task automatic noise(input int n);
        pfta_pkg::item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.mode = ($urandom_range(0, 1) == 0) ? pfta_pkg::MODE_FRAME : pfta_pkg::MODE_PPS;
            it.local_time_ns = ($urandom_range(0, 4) == 0) ? 63'($urandom) : rand63();
            it.gps_time_ns = ($urandom_range(0, 3) == 0) ? board.pps_gps : rand63();
            put(it);
        end
    endtask

    // pulses each followed by a far-off frame, to drive the lost total
    // into saturation
    task automatic loss_storm(input int n);
        longint far, dly;
        dly = longint'(board.xfer_dly) + longint'(board.expo_dly);
        for (int i = 0; i < n; i++)
        begin
            sec_local += SEC_NS;
            sec_gps   += SEC_NS;
            put(pps_item(sec_local + longint'(board.serial_dly), sec_gps));
            far = longint'($urandom_range(30, 2000)) * SEC_NS;
            // some frames land well before the pulse instead
            if ($urandom_range(0, 9) == 0)
                far = -far / 100;
            put(frame_item(sec_local + far + dly));
        end
    endtask

    initial
    begin : main_seq
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_max = 3;
        directed();

        sec_local = longint'($urandom_range(1 << 8, 1 << 28)) << 32;
        sec_gps   = 63'($urandom_range(1 << 8, 1 << 28)) << 32;

        // typical delays, with a long result hold-off in the middle
        configure(30'($urandom_range(0, 20 * MS)), 30'($urandom_range(0, 30 * MS)),
                  30'($urandom_range(0, 60 * MS)), 30'($urandom_range(20 * MS, 80 * MS)));
        gap_max = 6;
        run_seconds(12);
        hold_cycles = HOLD_LEN;
        gap_max = 0;
        run_seconds(3);
        gap_max = 6;
        run_seconds(15);

        // extremes: nothing counts as aligned, then everything at maximum
        configure('0, '0, '0, '0);
        gap_max = 0;
        run_seconds(15);
        configure(30'(CFG_MAX), 30'(CFG_MAX), 30'(CFG_MAX), 30'(CFG_MAX));
        gap_max = 10;
        run_seconds(15);

        configure(30'($urandom_range(0, CFG_MAX)), 30'($urandom_range(0, CFG_MAX)),
                  30'($urandom_range(0, CFG_MAX)), 30'($urandom_range(0, CFG_MAX)));
        gap_max = 4;
        noise(400);

        configure(30'($urandom_range(0, 20 * MS)), 30'($urandom_range(0, 30 * MS)),
                  30'($urandom_range(0, 60 * MS)), 30'($urandom_range(20 * MS, 80 * MS)));
        loss_storm(320);

        // sender pauses mid-phase until all stamps are back
        configure(30'($urandom_range(0, 20 * MS)), 30'($urandom_range(0, 30 * MS)),
                  30'($urandom_range(0, 60 * MS)), 30'($urandom_range(20 * MS, 80 * MS)));
        gap_max = 8;
        run_seconds(10);
        drain();
        gap_max = 2;
        run_seconds(10);

        drain();
        repeat (TAIL) @(posedge clk);
        if (board.errs == 0 && board.pending() == 0)
            $display("[pps_frame_timestamp_aligner] OK");
        else
            $display("[pps_frame_timestamp_aligner] ERROR");
        $finish;
    end

endmodule
